>>> sv/pida_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pida_pkg
// Shared widths, request and status codes, and the command that the control
// logic broadcasts to every storage cell of the positional array.
// ----------------------------------------------------------------------------
package pida_pkg;

	localparam int KIND_W        = 3;
	localparam int DATA_W        = 32;
	localparam int POS_W         = 7;
	localparam int STATUS_W      = 3;
	localparam int DEPTH_DEFAULT = 64;

	// Request kinds carried on the input tuser.
	localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DISPLAY = 3'd2;
	localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd4;

	// Result status codes carried on the output tuser.
	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BADPOS     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TOOMANY    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_ELEMENT    = 3'd5;
	localparam logic [STATUS_W-1:0] ST_UNEXPECTED = 3'd6;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD,
		OP_INSERT,
		OP_DELETE,
		OP_ROTATE
	} cell_op_t;

	// Command seen by every cell in the same cycle.
	typedef struct packed {
		cell_op_t          op;
		logic [DATA_W-1:0] value;  // value for load or insert
		logic [POS_W-1:0]  idx;    // zero-based target of insert or delete
		logic [POS_W-1:0]  len;    // current length of the store
		logic [POS_W-1:0]  fill;   // slot that a load writes
	} cell_cmd_t;

endpackage

>>> sv/pida_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pida_cell
// One storage slot of the chain; takes a new value, its lower or upper
// neighbor's value, or the head value, as the broadcast command asks.
// ----------------------------------------------------------------------------
module pida_cell #(
	parameter int INDEX = 0
) (
	input  logic                        clk,
	input  pida_pkg::cell_cmd_t         cmd,
	input  logic [pida_pkg::DATA_W-1:0] prev_data,
	input  logic [pida_pkg::DATA_W-1:0] next_data,
	input  logic [pida_pkg::DATA_W-1:0] head_data,
	output logic [pida_pkg::DATA_W-1:0] data
);

	localparam logic [pida_pkg::POS_W-1:0] IDX  = pida_pkg::POS_W'(INDEX);
	localparam logic [pida_pkg::POS_W-1:0] IDX1 = pida_pkg::POS_W'(INDEX + 1);

	logic [pida_pkg::DATA_W-1:0] data_q;
	logic [pida_pkg::DATA_W-1:0] data_nxt;

	always_comb begin
		data_nxt = data_q;
		unique case (cmd.op)
			pida_pkg::OP_LOAD: begin
				if (cmd.fill == IDX) data_nxt = cmd.value;
			end
			pida_pkg::OP_INSERT: begin
				if (cmd.idx == IDX) data_nxt = cmd.value;
				else if (IDX > cmd.idx && IDX <= cmd.len) data_nxt = prev_data;
			end
			pida_pkg::OP_DELETE: begin
				if (IDX >= cmd.idx && IDX1 < cmd.len) data_nxt = next_data;
			end
			pida_pkg::OP_ROTATE: begin
				// The occupied part of the chain turns by one toward the head.
				if (IDX1 < cmd.len) data_nxt = next_data;
				else if (IDX1 == cmd.len) data_nxt = head_data;
			end
			default: data_nxt = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign data = data_q;

endmodule

>>> sv/positional_insert_delete_array.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_delete_array
// Ordered store of signed 32-bit values with create, load, insert, delete and
// display requests, built as a chain of storage cells.
// ----------------------------------------------------------------------------
// A create, load, insert or delete request gives one result. Insert and
// delete move every later entry by one slot at once, because each cell loads
// from its neighbor in parallel. A display request of a store with N entries
// holds the block until it has given one result per element, each when the
// output register is free, since the entries leave through the head cell
// while the occupied part of the chain rotates; after N steps the chain is
// back in its original order. An empty display gives a
// single result with status empty. The block takes one request at a time and
// accepts a new one only when the output register is free or is being
// emptied in the same cycle. Slots that a create announced but no load
// filled hold unknown data until they are written.
module positional_insert_delete_array #(
	parameter int DEPTH = pida_pkg::DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request channel.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] value, [38:32] position, [39] zero
	input  logic [2:0]  s_tuser,   // [2:0] kind
	// Result channel.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] element
	output logic [2:0]  m_tuser,   // [2:0] status
	output logic        m_tlast    // last result of this request
);

	localparam int DW = pida_pkg::DATA_W;
	localparam int PW = pida_pkg::POS_W;
	localparam logic [PW-1:0] DEPTH_L = PW'(DEPTH);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_DISP = 2'b10
	} state_t;

	state_t  state_q, state_nxt;
	logic [PW-1:0] length_q, length_nxt;
	logic [PW-1:0] fill_q, fill_nxt;
	logic [PW-1:0] cnt_q, cnt_nxt;

	logic                         m_tvalid_q;
	logic [pida_pkg::STATUS_W-1:0] status_q;
	logic [DW-1:0]                element_q;
	logic                         last_q;

	logic                          res_valid;
	logic [pida_pkg::STATUS_W-1:0] res_status;
	logic [DW-1:0]                 res_element;
	logic                          res_last;

	pida_pkg::cell_cmd_t cmd;
	logic [DW-1:0] cell_data [DEPTH];

	logic [pida_pkg::KIND_W-1:0] kind;
	logic [DW-1:0] value;
	logic [PW-1:0] pos;
	logic          out_free;
	logic          accept;

	assign kind  = s_tuser;
	assign value = s_tdata[31:0];
	assign pos   = s_tdata[38:32];

	// The output register can take a new result when it is empty or drains now.
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_nxt   = state_q;
		length_nxt  = length_q;
		fill_nxt    = fill_q;
		cnt_nxt     = cnt_q;
		res_valid   = 1'b0;
		res_status  = pida_pkg::ST_OK;
		res_element = '0;
		res_last    = 1'b1;
		cmd.op      = pida_pkg::OP_HOLD;
		cmd.value   = value;
		cmd.idx     = pos - PW'(1);
		cmd.len     = length_q;
		cmd.fill    = fill_q;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (kind)
						pida_pkg::KIND_CREATE: begin
							res_valid = 1'b1;
							fill_nxt  = '0;
							if (pos > DEPTH_L) begin
								length_nxt = '0;
								res_status = pida_pkg::ST_TOOMANY;
							end else begin
								length_nxt = pos;
							end
						end
						pida_pkg::KIND_LOAD: begin
							res_valid = 1'b1;
							if (fill_q >= length_q || fill_q >= DEPTH_L) begin
								res_status = pida_pkg::ST_UNEXPECTED;
							end else begin
								cmd.op   = pida_pkg::OP_LOAD;
								fill_nxt = fill_q + PW'(1);
							end
						end
						pida_pkg::KIND_DISPLAY: begin
							if (length_q == '0) begin
								res_valid  = 1'b1;
								res_status = pida_pkg::ST_EMPTY;
							end else begin
								state_nxt = S_DISP;
								cnt_nxt   = '0;
							end
						end
						pida_pkg::KIND_INSERT: begin
							res_valid = 1'b1;
							if (length_q >= DEPTH_L) begin
								res_status = pida_pkg::ST_FULL;
							end else if (pos == '0 ||
								{1'b0, pos} > ({1'b0, length_q} + (PW + 1)'(1))) begin
								res_status = pida_pkg::ST_BADPOS;
							end else begin
								cmd.op     = pida_pkg::OP_INSERT;
								length_nxt = length_q + PW'(1);
								fill_nxt   = length_q + PW'(1);
							end
						end
						pida_pkg::KIND_DELETE: begin
							res_valid = 1'b1;
							if (length_q == '0) begin
								res_status = pida_pkg::ST_EMPTY;
							end else if (pos == '0 || pos > length_q) begin
								res_status = pida_pkg::ST_BADPOS;
							end else begin
								cmd.op     = pida_pkg::OP_DELETE;
								length_nxt = length_q - PW'(1);
								fill_nxt   = length_q - PW'(1);
							end
						end
						default: begin
							// Undefined kinds are taken and dropped without a result.
						end
					endcase
				end
			end
			S_DISP: begin
				// One element leaves through the head cell each free cycle.
				if (out_free) begin
					cmd.op      = pida_pkg::OP_ROTATE;
					res_valid   = 1'b1;
					res_status  = pida_pkg::ST_ELEMENT;
					res_element = cell_data[0];
					res_last    = (cnt_q + PW'(1)) == length_q;
					cnt_nxt     = cnt_q + PW'(1);
					if (res_last) state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			length_q   <= '0;
			fill_q     <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			length_q <= length_nxt;
			fill_q   <= fill_nxt;
			cnt_q    <= cnt_nxt;
			if (res_valid) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			status_q  <= res_status;
			element_q <= res_element;
			last_q    <= res_last;
		end
	end

	// The chain: each cell sees both neighbors and the head cell.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [DW-1:0] prev_d;
		logic [DW-1:0] next_d;

		if (g == 0) begin : g_first
			assign prev_d = '0;
		end else begin : g_prev
			assign prev_d = cell_data[g-1];
		end

		if (g == DEPTH - 1) begin : g_end
			assign next_d = '0;
		end else begin : g_next
			assign next_d = cell_data[g+1];
		end

		pida_cell #(
			.INDEX(g)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.prev_data(prev_d),
			.next_data(next_d),
			.head_data(cell_data[0]),
			.data     (cell_data[g])
		);
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = element_q;
	assign m_tuser  = status_q;
	assign m_tlast  = last_q;

endmodule

>>> sv/pida_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pida_checker
// Port-level checks of the positional array, attached to the top level.
// ----------------------------------------------------------------------------
module pida_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [2:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
		$stable(m_tuser) && $stable(m_tlast))
		else $error("stalled result changed");

	// A new request is only taken when the result register can make room.
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid || m_tready)
		else $error("request taken while a result is stalled");

	// Status results carry a zero element and close their request.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != pida_pkg::ST_ELEMENT |-> m_tdata == '0 && m_tlast)
		else $error("status result with element or without last");

	// Single-result requests answer in the next cycle.
	a_answer: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == pida_pkg::KIND_CREATE ||
		s_tuser == pida_pkg::KIND_LOAD || s_tuser == pida_pkg::KIND_INSERT ||
		s_tuser == pida_pkg::KIND_DELETE) |=> m_tvalid && m_tlast)
		else $error("missing result for request");

endmodule

bind positional_insert_delete_array pida_checker u_pida_checker (.*);
